// File: hw/rtl/okvt_pkg.sv
// okvt_pkg: shared types, codes and stream layout of the ordered key/value table
// used by okvt_cell, ordered_key_value_table_unit and okvt_checker
// no dependencies
package okvt_pkg;

  // default sizes
  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // fixed field widths of the words
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned STS_W   = 3;
  localparam int unsigned CNT_W   = 6;

  // input word layout, lowest bit first
  localparam int unsigned IN_OP_LSB  = 0;
  localparam int unsigned IN_KEY_LSB = IN_OP_LSB + OP_W;
  localparam int unsigned IN_VAL_LSB = IN_KEY_LSB + KEY_W;
  localparam int unsigned IN_POS_LSB = IN_VAL_LSB + VALUE_W;
  localparam int unsigned IN_BITS    = IN_POS_LSB + POS_W;
  localparam int unsigned S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // output word layout, lowest bit first
  localparam int unsigned OUT_OK_LSB   = 0;
  localparam int unsigned OUT_STS_LSB  = OUT_OK_LSB + 1;
  localparam int unsigned OUT_KEY_LSB  = OUT_STS_LSB + STS_W;
  localparam int unsigned OUT_VAL_LSB  = OUT_KEY_LSB + KEY_W;
  localparam int unsigned OUT_CNT_LSB  = OUT_VAL_LSB + VALUE_W;
  localparam int unsigned OUT_EMP_LSB  = OUT_CNT_LSB + CNT_W;
  localparam int unsigned OUT_BITS     = OUT_EMP_LSB + 1;
  localparam int unsigned M_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_UPSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_LOOKUP = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [STS_W-1:0] {
    STS_DONE      = 3'd0,
    STS_EXISTS    = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_FULL      = 3'd3,
    STS_RANGE     = 3'd4
  } status_e;

  // what every cell does in the execute cycle
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_PUSH  = 2'd1,  // take the left neighbour's entry
    ACT_WRITE = 2'd2,  // matching cell takes the new value
    ACT_PULL  = 2'd3   // cells at and after the erased one take the right neighbour's
  } cell_act_e;

  typedef struct packed {
    logic      cmp_en;  // compare the incoming key this cycle
    cell_act_e act;
    logic      by_pos;  // select by position rather than by key match
  } cell_ctl_t;

endpackage

// File: hw/rtl/okvt_cell.sv
// okvt_cell: one entry of the table with its key comparator and neighbour shift
// depends on okvt_pkg
module okvt_cell import okvt_pkg::*; #(
  parameter int unsigned KW  = 32,
  parameter int unsigned VW  = 32,
  parameter int unsigned IW  = 5,
  parameter int unsigned CW  = 6,
  parameter int unsigned PW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctl_t     ctl_i,
  input  logic [KW-1:0] cmp_key_i,
  input  logic [VW-1:0] wr_val_i,
  input  logic [KW-1:0] left_key_i,
  input  logic [VW-1:0] left_val_i,
  input  logic [KW-1:0] right_key_i,
  input  logic [VW-1:0] right_val_i,
  input  logic [CW-1:0] count_i,
  input  logic [IW-1:0] hit_idx_i,
  input  logic [PW-1:0] pos_i,
  output logic [KW-1:0] key_o,
  output logic [VW-1:0] val_o,
  output logic          hit_o,
  output logic [KW-1:0] sel_key_o,
  output logic [VW-1:0] sel_val_o
);

  logic [KW-1:0] key_q, key_d;
  logic [VW-1:0] val_q, val_d;
  logic          hit_q, hit_d;
  logic          valid;
  logic          sel;

  assign valid = CW'(IDX) < count_i;
  assign hit_d = ctl_i.cmp_en ? (valid && (key_q == cmp_key_i)) : hit_q;
  assign sel   = ctl_i.by_pos ? (pos_i == PW'(IDX)) : hit_q;

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    case (ctl_i.act)
      ACT_PUSH: begin
        key_d = left_key_i;
        val_d = left_val_i;
      end
      ACT_WRITE: begin
        if (hit_q) begin
          val_d = wr_val_i;
        end
      end
      ACT_PULL: begin
        if (IW'(IDX) >= hit_idx_i) begin
          key_d = right_key_i;
          val_d = right_val_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o     = key_q;
  assign val_o     = val_q;
  assign hit_o     = hit_q;
  assign sel_key_o = sel ? key_q : '0;
  assign sel_val_o = sel ? val_q : '0;

endmodule

// File: hw/rtl/ordered_key_value_table_unit.sv
// ordered_key_value_table_unit: top level of the ordered key/value table
// depends on okvt_pkg and okvt_cell
//
// bounded associative table of unique keys, newest entry at position 0, built as a
// row of CAPACITY cells; each word on the input stream is one operation (insert,
// update, insert-or-update, erase, lookup, read by position) and gives exactly one
// result word. in the cycle the word is accepted every cell compares its key with
// the incoming key at once; in the execute state that follows the match vector
// decides the action: every cell shifts right (insert), the cells from the erased
// place shift left (erase) or the matching cell rewrites its value (update), and
// the result is loaded into the output register; execute holds while a previous
// result waits there. tready is high only between operations, so a word is taken
// only once the previous one is done; a word may be accepted while the previous
// result still waits. storage is cell registers only, no clearing pass after reset
module ordered_key_value_table_unit import okvt_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // op[2:0], key[34:3], value[66:35], position[72:67], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // ok[0], status[3:1], key_out[35:4], value_out[67:36], entry_count[73:68],
  // is_empty[74], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  // stored widths: the ports carry 32 bits, so wider key and value settings are capped at 32
  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_EXEC = 2'b10
  } fsm_e;

  fsm_e state_q, state_d;

  // latched operation
  logic [OP_W-1:0]  op_q;
  logic [KW-1:0]    key_q;
  logic [VW-1:0]    val_q;
  logic [POS_W-1:0] pos_q;

  logic [CW-1:0] cnt_q, cnt_d;

  logic                 m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  logic s_acc;
  logic fire;

  // cell row
  cell_ctl_t     ctl;
  logic [KW-1:0] cell_key     [CAPACITY];
  logic [VW-1:0] cell_val     [CAPACITY];
  logic [KW-1:0] cell_sel_key [CAPACITY];
  logic [VW-1:0] cell_sel_val [CAPACITY];
  logic [CAPACITY-1:0] hit;

  logic [KW-1:0] in_key;
  logic [IW-1:0] hit_idx;
  logic          any_hit;
  logic [KW-1:0] sel_key;
  logic [VW-1:0] sel_val;
  logic          full;
  logic          in_range;

  // result fields
  logic          res_ok;
  status_e       res_sts;
  logic [KW-1:0] res_key;
  logic [VW-1:0] res_val;
  logic [M_TDATA_W-1:0] res_word;

  assign s_axis_tready_o = (state_q == FSM_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = (state_q == FSM_EXEC) && (!m_valid_q || m_axis_tready_i);

  // key masked to the stored width, compared straight off the input word
  assign in_key = s_axis_tdata_i[IN_KEY_LSB +: KW];

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KW-1:0] lk, rk;
      logic [VW-1:0] lv, rv;
      if (i == 0) begin : g_head
        // the head cell takes the new entry on insert
        assign lk = key_q;
        assign lv = val_q;
      end else begin : g_mid
        assign lk = cell_key[i-1];
        assign lv = cell_val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign rk = cell_key[i];
        assign rv = cell_val[i];
      end else begin : g_body
        assign rk = cell_key[i+1];
        assign rv = cell_val[i+1];
      end

      okvt_cell #(
        .KW  (KW),
        .VW  (VW),
        .IW  (IW),
        .CW  (CW),
        .PW  (PW),
        .IDX (i)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .cmp_key_i   (in_key),
        .wr_val_i    (val_q),
        .left_key_i  (lk),
        .left_val_i  (lv),
        .right_key_i (rk),
        .right_val_i (rv),
        .count_i     (cnt_q),
        .hit_idx_i   (hit_idx),
        .pos_i       (PW'(pos_q)),
        .key_o       (cell_key[i]),
        .val_o       (cell_val[i]),
        .hit_o       (hit[i]),
        .sel_key_o   (cell_sel_key[i]),
        .sel_val_o   (cell_sel_val[i])
      );
    end
  endgenerate

  // keys are unique, so the match vector is one-hot or empty: plain or-trees
  always_comb begin
    hit_idx = '0;
    sel_key = '0;
    sel_val = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      hit_idx = hit_idx | (hit[i] ? IW'(i) : '0);
      sel_key = sel_key | cell_sel_key[i];
      sel_val = sel_val | cell_sel_val[i];
    end
  end

  assign any_hit  = |hit;
  assign full     = (cnt_q == CW'(CAPACITY));
  assign in_range = PW'(pos_q) < PW'(cnt_q);

  // operation decode in the execute cycle
  always_comb begin
    ctl.cmp_en = s_acc;
    ctl.act    = ACT_NONE;
    ctl.by_pos = (op_q == OP_READ);
    cnt_d      = cnt_q;
    res_ok     = 1'b0;
    res_sts    = STS_DONE;
    res_key    = '0;
    res_val    = '0;
    unique case (op_q) inside
      OP_INSERT, OP_UPSERT: begin
        if (any_hit) begin
          if (op_q == OP_UPSERT) begin
            ctl.act = ACT_WRITE;
            res_ok  = 1'b1;
          end else begin
            res_sts = STS_EXISTS;
          end
        end else if (full) begin
          res_sts = STS_FULL;
        end else begin
          ctl.act = ACT_PUSH;
          cnt_d   = cnt_q + CW'(1);
          res_ok  = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (any_hit) begin
          ctl.act = ACT_WRITE;
          res_ok  = 1'b1;
        end else begin
          res_sts = STS_NOT_FOUND;
        end
      end
      OP_ERASE: begin
        if (any_hit) begin
          ctl.act = ACT_PULL;
          cnt_d   = cnt_q - CW'(1);
          res_ok  = 1'b1;
        end else begin
          res_sts = STS_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (any_hit) begin
          res_val = sel_val;
          res_ok  = 1'b1;
        end else begin
          res_sts = STS_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (in_range) begin
          res_key = sel_key;
          res_val = sel_val;
          res_ok  = 1'b1;
        end else begin
          res_sts = STS_RANGE;
        end
      end
      default: begin
        // unused op codes leave the table alone
      end
    endcase
    // the row only moves when the result can be taken
    if (!fire) begin
      ctl.act = ACT_NONE;
      cnt_d   = cnt_q;
    end
  end

  always_comb begin
    res_word = '0;
    res_word[OUT_OK_LSB]                = res_ok;
    res_word[OUT_STS_LSB +: STS_W]      = res_sts;
    res_word[OUT_KEY_LSB +: KEY_W]      = KEY_W'(res_key);
    res_word[OUT_VAL_LSB +: VALUE_W]    = VALUE_W'(res_val);
    res_word[OUT_CNT_LSB +: CNT_W]      = CNT_W'(cnt_d);
    res_word[OUT_EMP_LSB]               = (cnt_d == '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (s_acc) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (fire) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FSM_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q  <= s_axis_tdata_i[IN_OP_LSB +: OP_W];
      key_q <= in_key;
      val_q <= s_axis_tdata_i[IN_VAL_LSB +: VW];
      pos_q <= s_axis_tdata_i[IN_POS_LSB +: POS_W];
    end
    if (fire) begin
      m_data_q <= res_word;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// File: hw/rtl/okvt_checker.sv
// okvt_checker: port-level assertions for ordered_key_value_table_unit, with its bind
// depends on okvt_pkg
module okvt_checker import okvt_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o
);

  logic s_acc;
  logic ok;
  logic [STS_W-1:0] sts;

  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign ok    = m_axis_tdata_o[OUT_OK_LSB];
  assign sts   = m_axis_tdata_o[OUT_STS_LSB +: STS_W];

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // one operation at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("word accepted during execute");

  // with a free output at acceptance the result shows straight after the execute state
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !m_axis_tvalid_o |-> ##2 m_axis_tvalid_o)
    else $error("result missing after two cycles");

  // a failed operation returns no key and no value, a good one reports done
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (ok ? (sts == STS_DONE) :
      (m_axis_tdata_o[OUT_KEY_LSB +: KEY_W] == '0 &&
       m_axis_tdata_o[OUT_VAL_LSB +: VALUE_W] == '0)))
    else $error("inconsistent result word");

endmodule

bind ordered_key_value_table_unit okvt_checker u_okvt_checker (.*);

// File: verif/okvt_checker.sv
// okvt_scoreboard: watches both streams of the ordered key/value table, keeps its own
// copy of the table, predicts every result word and compares it field by field
// depends on okvt_pkg
module okvt_scoreboard import okvt_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? '1 : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));
  localparam logic [VALUE_W-1:0] VALUE_MASK =
    (VALUE_BITS >= VALUE_W) ? '1 : ((VALUE_W'(1) << VALUE_BITS) - VALUE_W'(1));

  typedef struct packed {
    logic               ok;
    status_e            status;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   count;
    logic               empty;
  } table_result_t;

  logic [KEY_W-1:0]   held_keys   [CAPACITY];
  logic [VALUE_W-1:0] held_values [CAPACITY];
  int unsigned        held_count;
  table_result_t      expected_q [$];
  int                 mismatches;
  int                 compared;

  // one operation on the shadow table, newest entry at index 0
  function automatic table_result_t apply_operation(logic [OP_W-1:0] op,
                                                     logic [KEY_W-1:0] key_in,
                                                     logic [VALUE_W-1:0] value_in,
                                                     logic [POS_W-1:0] pos);
    table_result_t res;
    logic [KEY_W-1:0] k;
    logic [VALUE_W-1:0] v;
    int at;
    int i;
    res = '0;
    res.status = STS_DONE;
    k = key_in & KEY_MASK;
    v = value_in & VALUE_MASK;
    at = -1;
    for (i = 0; i < int'(held_count); i++) begin
      if (at < 0 && held_keys[i] == k) at = i;
    end
    case (op)
      OP_INSERT, OP_UPSERT: begin
        if (at >= 0) begin
          if (op == OP_UPSERT) begin
            held_values[at] = v;
            res.ok = 1'b1;
          end else begin
            res.status = STS_EXISTS;
          end
        end else if (held_count >= CAPACITY) begin
          res.status = STS_FULL;
        end else begin
          for (i = int'(held_count); i > 0; i--) begin
            held_keys[i]   = held_keys[i-1];
            held_values[i] = held_values[i-1];
          end
          held_keys[0]   = k;
          held_values[0] = v;
          held_count++;
          res.ok = 1'b1;
        end
      end
      OP_UPDATE: begin
        if (at >= 0) begin
          held_values[at] = v;
          res.ok = 1'b1;
        end else begin
          res.status = STS_NOT_FOUND;
        end
      end
      OP_ERASE: begin
        if (at >= 0) begin
          for (i = at; i + 1 < int'(held_count); i++) begin
            held_keys[i]   = held_keys[i+1];
            held_values[i] = held_values[i+1];
          end
          held_count--;
          res.ok = 1'b1;
        end else begin
          res.status = STS_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (at >= 0) begin
          res.value = held_values[at];
          res.ok = 1'b1;
        end else begin
          res.status = STS_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (pos < held_count) begin
          res.key   = held_keys[pos];
          res.value = held_values[pos];
          res.ok = 1'b1;
        end else begin
          res.status = STS_RANGE;
        end
      end
      default: ;  // unused codes leave the table alone
    endcase
    res.count = CNT_W'(held_count);
    res.empty = (held_count == 0);
    return res;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    if (!rst_ni) begin
      held_count = 0;
      expected_q.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(apply_operation(s_tdata_i[IN_OP_LSB +: OP_W],
                                             s_tdata_i[IN_KEY_LSB +: KEY_W],
                                             s_tdata_i[IN_VAL_LSB +: VALUE_W],
                                             s_tdata_i[IN_POS_LSB +: POS_W]));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word %h with nothing expected", $realtime, m_tdata_i);
        end else begin
          want = expected_q.pop_front();
          compared++;
          check_field("ok", 32'(want.ok), 32'(m_tdata_i[OUT_OK_LSB]));
          check_field("status", 32'(want.status), 32'(m_tdata_i[OUT_STS_LSB +: STS_W]));
          check_field("key_out", want.key, m_tdata_i[OUT_KEY_LSB +: KEY_W]);
          check_field("value_out", want.value, m_tdata_i[OUT_VAL_LSB +: VALUE_W]);
          check_field("entry_count", 32'(want.count), 32'(m_tdata_i[OUT_CNT_LSB +: CNT_W]));
          check_field("is_empty", 32'(want.empty), 32'(m_tdata_i[OUT_EMP_LSB]));
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_q.size();
    checked_o    <= compared;
  end

endmodule

// File: verif/ordered_key_value_table_unit_tb.sv
// ordered_key_value_table_unit_tb: stimulus and verdict for the ordered key/value table
// depends on okvt_pkg, ordered_key_value_table_unit and okvt_scoreboard
module ordered_key_value_table_unit_tb import okvt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // op codes the block must ignore
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_WORDS = 1000;
  localparam int POOL_SIZE    = 40;  // a few more keys than the table holds, so it fills
  localparam int QUIET_LIMIT  = 2000;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int checked;

  bit steady;  // no idling on either side while set
  int words_sent;
  int op_sent [8];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  ordered_key_value_table_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  okvt_scoreboard checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side back-pressure, ready dropped at random with odds of 18 in a hundred unless steady is set
  initial m_axis_tready = 1'b0;
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
  end

  // watchdog: ends the run once nothing has moved on either stream for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // drives one operation word; called at a falling edge, returns at the falling edge
  // after the word was taken. valid stays high between words unless a gap is drawn
  task automatic send_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                           logic [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[IN_OP_LSB +: OP_W]     = op;
    word[IN_KEY_LSB +: KEY_W]   = key;
    word[IN_VAL_LSB +: VALUE_W] = value;
    word[IN_POS_LSB +: POS_W]   = pos;
    if (!steady && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    op_sent[op]++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    traffic_mode_e mode;
    int burst_left;
    int r;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    steady        = 1'b0;
    words_sent    = 0;
    foreach (op_sent[i]) op_sent[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part: empty table, extreme keys and values, every failure status but full
    send_word(OP_LOOKUP, 32'd5, 32'd0, 6'd0);          // lookup on empty table
    send_word(OP_READ, 32'd0, 32'd0, 6'd0);            // read on empty table
    send_word(OP_ERASE, 32'd5, 32'd0, 6'd0);           // erase of absent key
    send_word(OP_UPDATE, 32'd5, 32'd1, 6'd0);          // update of absent key
    send_word(OP_INSERT, 32'h0, 32'h0, 6'd0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_word(OP_INSERT, 32'h0, 32'h1234_5678, 6'd0);  // key already there
    send_word(OP_UPSERT, 32'h0, 32'hA5A5_A5A5, 6'd0);  // upsert takes the update path
    send_word(OP_UPSERT, 32'h1234_5678, 32'h1, 6'd0);  // upsert takes the insert path
    send_word(OP_UPDATE, 32'hFFFF_FFFF, 32'h0, 6'd0);
    send_word(OP_READ, 32'd0, 32'd0, 6'd0);
    send_word(OP_READ, 32'd0, 32'd0, 6'd2);            // oldest entry
    send_word(OP_READ, 32'd0, 32'd0, 6'd3);            // just past the end
    send_word(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'd0, 6'd0);
    send_word(OP_ERASE, 32'hFFFF_FFFF, 32'd0, 6'd0);   // erase from the middle
    send_word(OP_READ, 32'd0, 32'd0, 6'd1);
    send_word(OP_SPARE_LO, 32'h0, 32'h5555_5555, 6'd0);
    send_word(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_word(OP_ERASE, 32'h0, 32'd0, 6'd0);
    send_word(OP_ERASE, 32'h1234_5678, 32'd0, 6'd0);   // table empty again
    send_word(OP_LOOKUP, 32'h0, 32'd0, 6'd0);

    // hold off until the table has answered everything so far
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);

    // random part in bursts; the first one fills the table up to and past full
    mode = MODE_FILL;
    burst_left = 90;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (burst_left == 0) begin
        r = $urandom_range(0, 2);
        mode = (r == 0) ? MODE_FILL : (r == 1) ? MODE_DRAIN : MODE_MIX;
        burst_left = $urandom_range(20, 60);
      end
      burst_left--;
      steady = (n >= 400 && n < 550);
      if (n == 700) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end

      // op mix leans on inserts when filling and on erases when draining
      r = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:
          op = (r < 45) ? OP_INSERT : (r < 60) ? OP_UPSERT : (r < 68) ? OP_UPDATE :
               (r < 74) ? OP_ERASE  : (r < 84) ? OP_LOOKUP : (r < 97) ? OP_READ :
               (r < 98) ? OP_SPARE_LO : OP_SPARE_HI;
        MODE_DRAIN:
          op = (r < 10) ? OP_INSERT : (r < 18) ? OP_UPSERT : (r < 26) ? OP_UPDATE :
               (r < 60) ? OP_ERASE  : (r < 75) ? OP_LOOKUP : (r < 97) ? OP_READ :
               (r < 98) ? OP_SPARE_LO : OP_SPARE_HI;
        default:
          op = (r < 20) ? OP_INSERT : (r < 32) ? OP_UPSERT : (r < 44) ? OP_UPDATE :
               (r < 58) ? OP_ERASE  : (r < 74) ? OP_LOOKUP : (r < 97) ? OP_READ :
               (r < 98) ? OP_SPARE_LO : OP_SPARE_HI;
      endcase

      // keys mostly from the pool so that hits are common, a few fresh ones as noise
      key = ($urandom_range(0, 99) < 92) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : $urandom;
      // positions mostly near the occupied range, sometimes anywhere
      pos = ($urandom_range(0, 99) < 80) ? POS_W'($urandom_range(0, 33))
                                         : POS_W'($urandom_range(0, 63));
      send_word(op, key, $urandom, pos);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // drain the remaining results, then let the pipeline settle
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("run covered %0d operation words: %0d insert, %0d update, %0d upsert,",
             words_sent, op_sent[OP_INSERT], op_sent[OP_UPDATE], op_sent[OP_UPSERT]);
    $display("  %0d erase, %0d lookup, %0d read, %0d unused codes; %0d results compared",
             op_sent[OP_ERASE], op_sent[OP_LOOKUP], op_sent[OP_READ],
             op_sent[OP_SPARE_LO] + op_sent[OP_SPARE_HI], checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: ordered_key_value_table_unit.f
hw/rtl/okvt_pkg.sv
hw/rtl/okvt_cell.sv
hw/rtl/ordered_key_value_table_unit.sv
hw/rtl/okvt_checker.sv
verif/okvt_checker.sv
verif/ordered_key_value_table_unit_tb.sv
